// ===== design/dcfp_pkg.sv =====
// Shared types, character codes and helpers for the command frame parser.
`default_nettype none

package dcfp_pkg;

    localparam int unsigned DCFP_FRAME_LEN = 24;

    localparam logic [7:0] CH_HEADER = 8'h4D;  // 'M'
    localparam logic [7:0] CH_DELIM  = 8'h5F;  // '_'
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Field numbers, counted by closing delimiters.
    localparam logic [3:0] FLD_WHEEL_DIR   = 4'd1;
    localparam logic [3:0] FLD_WHEEL_RATE  = 4'd2;
    localparam logic [3:0] FLD_BRUSH_CMD   = 4'd3;
    localparam logic [3:0] FLD_BRUSH_RATE  = 4'd4;
    localparam logic [3:0] FLD_AUTO_MODE   = 4'd5;
    localparam logic [3:0] FLD_PUMP_CMD    = 4'd6;
    localparam logic [3:0] FLD_LINE_FLAG   = 4'd7;
    localparam logic [3:0] FLD_DIRT_FLAG   = 4'd8;
    localparam logic [3:0] FLD_SATURATED   = 4'd9;

    localparam int unsigned OUT_TDATA_W = 72;

    typedef struct packed {
        logic       bad;
        logic [7:0] wheel_dir;
        logic [9:0] wheel_rate;
        logic [7:0] brush_cmd;
        logic [9:0] brush_rate;
        logic [7:0] auto_mode;
        logic [7:0] pump_cmd;
        logic [7:0] line_flag;
        logic [7:0] dirt_flag;
    } t_frame_res;

    // A byte outside '0'..'9' counts as zero.
    function automatic logic [3:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = c - CH_ZERO;
            digit_val = (c >= CH_ZERO && c <= CH_NINE) ? d[3:0] : 4'd0;
        end
    endfunction

    function automatic logic [9:0] speed_val(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2);
        begin
            speed_val = 10'(digit_val(c0)) * 10'd100 + 10'(digit_val(c1)) * 10'd10
                      + 10'(digit_val(c2));
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/delimited_command_frame_parser_core.sv =====
// Top level of the delimited command frame parser with stream handshakes.
`default_nettype none

// Takes one received byte per beat and closes a frame every FRAME_LEN bytes,
// giving one result beat per frame. A byte can be accepted in every cycle;
// it goes through an input register, the parser's per-byte update and a
// result register, which offers the frame's result after the last byte
// has passed from the input register. The input side stalls only when a
// new result is ready while the previous one has not yet been taken. Result
// tlast is always set, tuser carries the bad-frame flag, and on a bad
// frame every tdata field is zero.
module delimited_command_frame_parser_core #(
    parameter int unsigned FRAME_LEN = dcfp_pkg::DCFP_FRAME_LEN
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [7:0]                        i_s_axis_tdata,   // rx_byte
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [7:0] wheel_dir, [17:8] wheel_rate, [25:18] brush_cmd,
    // [35:26] brush_rate, [43:36] auto_mode, [51:44] pump_cmd,
    // [59:52] line_flag, [67:60] dirt_flag, [71:68] zero
    output logic [dcfp_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,   // frame_done
    output logic                                   o_m_axis_tuser    // frame_bad
);
    import dcfp_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic             r_out_bad;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic             w_last;
    logic             w_advance;
    t_frame_res       w_res;

    dcfp_parse #(
        .FRAME_LEN(FRAME_LEN)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_advance),
        .i_byte (r_in_byte),
        .o_last (w_last),
        .o_res  (w_res)
    );

    // Only the closing byte of a frame needs room in the result register.
    assign w_advance       = r_in_valid && (!w_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_last) begin
            r_out_bad  <= w_res.bad;
            r_out_data <= {4'd0, w_res.dirt_flag, w_res.line_flag, w_res.pump_cmd,
                           w_res.auto_mode, w_res.brush_rate, w_res.brush_cmd,
                           w_res.wheel_rate, w_res.wheel_dir};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = 1'b1;
    assign o_m_axis_tuser  = r_out_bad;

endmodule

`default_nettype wire

// ===== design/dcfp_parse.sv =====
// Per-byte frame parser: field tracking, field store and frame result.
`default_nettype none

module dcfp_parse #(
    parameter int unsigned FRAME_LEN = dcfp_pkg::DCFP_FRAME_LEN
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    output logic                      o_last,
    output dcfp_pkg::t_frame_res      o_res
);
    import dcfp_pkg::*;

    localparam int unsigned POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [3:0]       r_field_count, n_field_count;
    logic [1:0]       r_char_pos, n_char_pos;
    logic [7:0]       r_prev_byte, n_prev_byte;
    logic             r_header_ok, n_header_ok;
    logic             r_stopped, n_stopped;
    logic [7:0]       r_char_fields [6];
    logic [7:0]       n_char_fields [6];
    logic [7:0]       r_speed_digits [6];
    logic [7:0]       n_speed_digits [6];
    logic [7:0]       r_pending [3];
    logic [7:0]       n_pending [3];

    assign o_last = (r_byte_pos == LAST_POS);

    always_comb begin
        n_byte_pos     = r_byte_pos + POS_W'(1);
        n_field_count  = r_field_count;
        n_char_pos     = r_char_pos;
        n_prev_byte    = i_byte;
        n_header_ok    = r_header_ok;
        n_stopped      = r_stopped;
        n_char_fields  = r_char_fields;
        n_speed_digits = r_speed_digits;
        n_pending      = r_pending;

        if (r_byte_pos == '0) begin
            n_header_ok = (i_byte == CH_HEADER);
        end

        if (!r_stopped) begin
            if (i_byte == CH_DELIM) begin
                // An underscore right after an 'M' byte (the header code) restarts the field count.
                if (r_prev_byte == CH_HEADER) begin
                    n_field_count = '0;
                end else begin
                    if (r_field_count < FLD_SATURATED) begin
                        n_field_count = r_field_count + 4'd1;
                    end
                    case (n_field_count)
                        FLD_WHEEL_RATE: begin
                            for (int k = 0; k < 3; k++) begin
                                if (2'(k) < r_char_pos) n_speed_digits[k] = r_pending[k];
                            end
                        end
                        FLD_BRUSH_RATE: begin
                            for (int k = 0; k < 3; k++) begin
                                if (2'(k) < r_char_pos) n_speed_digits[k+3] = r_pending[k];
                            end
                        end
                        FLD_WHEEL_DIR: begin
                            if (r_char_pos != '0) n_char_fields[0] = r_pending[0];
                        end
                        FLD_BRUSH_CMD: begin
                            if (r_char_pos != '0) n_char_fields[1] = r_pending[0];
                        end
                        FLD_AUTO_MODE: begin
                            if (r_char_pos != '0) n_char_fields[2] = r_pending[0];
                        end
                        FLD_PUMP_CMD: begin
                            if (r_char_pos != '0) n_char_fields[3] = r_pending[0];
                        end
                        FLD_LINE_FLAG: begin
                            if (r_char_pos != '0) n_char_fields[4] = r_pending[0];
                        end
                        FLD_DIRT_FLAG: begin
                            if (r_char_pos != '0) n_char_fields[5] = r_pending[0];
                        end
                        default: begin
                        end
                    endcase
                end
                n_char_pos = '0;
            end else if (i_byte == CH_LF && r_prev_byte == CH_CR) begin
                n_stopped = 1'b1;
            end else if (r_char_pos != 2'd3) begin
                n_pending[r_char_pos] = i_byte;
                n_char_pos            = r_char_pos + 2'd1;
            end
        end
    end

    // A good frame ends in LF, which never commits a field, so the result
    // reads the stored fields directly.
    always_comb begin
        o_res     = '0;
        o_res.bad = !(r_header_ok && i_byte == CH_LF);
        if (!o_res.bad) begin
            o_res.wheel_dir   = r_char_fields[0];
            o_res.wheel_rate  = speed_val(r_speed_digits[0], r_speed_digits[1],
                                          r_speed_digits[2]);
            o_res.brush_cmd   = r_char_fields[1];
            o_res.brush_rate  = speed_val(r_speed_digits[3], r_speed_digits[4],
                                          r_speed_digits[5]);
            o_res.auto_mode   = r_char_fields[2];
            o_res.pump_cmd    = r_char_fields[3];
            o_res.line_flag   = r_char_fields[4];
            o_res.dirt_flag   = r_char_fields[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && o_last)) begin
            r_byte_pos     <= '0;
            r_field_count  <= '0;
            r_char_pos     <= '0;
            r_prev_byte    <= '0;
            r_header_ok    <= 1'b0;
            r_stopped      <= 1'b0;
            r_char_fields  <= '{default: '0};
            r_speed_digits <= '{default: '0};
            r_pending      <= '{default: '0};
        end else if (i_step) begin
            r_byte_pos     <= n_byte_pos;
            r_field_count  <= n_field_count;
            r_char_pos     <= n_char_pos;
            r_prev_byte    <= n_prev_byte;
            r_header_ok    <= n_header_ok;
            r_stopped      <= n_stopped;
            r_char_fields  <= n_char_fields;
            r_speed_digits <= n_speed_digits;
            r_pending      <= n_pending;
        end
    end

`ifndef SYNTHESIS
    a_field_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_count <= FLD_SATURATED)
        else $error("field count beyond saturation");

    a_frame_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_last |=> r_byte_pos == '0 && !r_stopped && r_field_count == '0)
        else $error("frame state not cleared after the closing byte");

    a_stopped_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped && i_step && !o_last |=> $stable(r_field_count) && $stable(r_char_pos))
        else $error("parsing continued after CR LF");
`endif

endmodule

`default_nettype wire
